// ===== rtl/tcp_option_mss_extractor_unit_defines.svh =====
// ----------------------------------------------------------------------------
// TCP option MSS extractor assertion macros
// Shared concurrent assertion shorthands for the extractor RTL.
// ----------------------------------------------------------------------------
`ifndef TCP_OPTION_MSS_EXTRACTOR_UNIT_DEFINES_SVH
`define TCP_OPTION_MSS_EXTRACTOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked only outside reset.
`define TOME_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tome: same-cycle check failed");

// Next-cycle implication, checked only outside reset.
`define TOME_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tome: next-cycle check failed");

`endif

// ===== rtl/tome_pkg.sv =====
// ----------------------------------------------------------------------------
// TCP option MSS extractor package
// Types, option codes and field widths shared by the extractor modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tome_pkg;

	localparam int unsigned ByteW   = 8;
	localparam int unsigned MssW    = 16;
	localparam int unsigned StatW   = 2;
	localparam int unsigned LeftW   = 6;
	localparam int unsigned OutW    = MssW + 1 + StatW;
	localparam int unsigned OutBusW = ((OutW + 7) / 8) * 8;

	localparam logic [ByteW-1:0] KindEol = 8'd0;
	localparam logic [ByteW-1:0] KindNop = 8'd1;
	localparam logic [ByteW-1:0] KindMss = 8'd2;
	localparam logic [ByteW-1:0] MssLen  = 8'd4;
	localparam logic [ByteW-1:0] MinLen  = 8'd2;
	localparam logic [ByteW-1:0] AreaMax = 8'd40;

	localparam logic [StatW-1:0] StOk      = 2'd0;
	localparam logic [StatW-1:0] StSilly   = 2'd1;
	localparam logic [StatW-1:0] StPartial = 2'd2;

	typedef enum logic [1:0] {
		PH_KIND,
		PH_LEN,
		PH_BODY
	} phase_t;

	typedef struct packed {
		logic [MssW-1:0]  mss_value;
		logic             mss_found;
		logic [StatW-1:0] parse_status;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/tcp_option_mss_extractor_unit.sv =====
// ----------------------------------------------------------------------------
// TCP option MSS extractor
// Parses the option bytes of a TCP header and reports the MSS value.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Fields (low bit first)                        Per
//  s_*       in         tdata: opt_byte[7:0]; tlast: last_byte        one option byte
//  m_*       out        tdata: mss_value[15:0], mss_found, status     one header
//
// Every option byte passes through the input register and one pass of the
// parser logic; a result appears on m_* at the edge at which its last byte
// leaves the input register, so throughput is one byte per clock unless a
// last byte waits in the input register for the output slot.
// The asynchronous reset clears the valid flags of the input and output registers
// and the parse state; no clearing pass is needed afterwards.
// A stalled output only holds back a byte flagged as last; other bytes keep
// flowing into the parse state while a finished result waits.
// ----------------------------------------------------------------------------
`default_nettype none

`include "tcp_option_mss_extractor_unit_defines.svh"

module tcp_option_mss_extractor_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// Input transactions: one option byte each.
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [tome_pkg::ByteW-1:0]    s_tdata,   // [7:0] opt_byte
	input  wire logic                          s_tlast,   // last_byte
	// Output transactions: one result per header.
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [tome_pkg::OutBusW-1:0]       m_tdata    // [15:0] mss_value,
	                                                      // [16] mss_found,
	                                                      // [18:17] parse_status,
	                                                      // [23:19] zero
);

	logic                          valid_s1;
	logic [tome_pkg::ByteW-1:0]    byte_s1;
	logic                          last_s1;
	logic                          step;
	logic                          free;
	tome_pkg::result_t             result;

	// The staged byte moves into the parser unless it closes a header and the
	// output slot is still occupied.
	assign step     = valid_s1 && (!last_s1 || free);
	assign s_tready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	tome_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.opt_byte  (byte_s1),
		.last_byte (last_s1),
		.result    (result)
	);

	tome_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (step && last_s1),
		.result   (result),
		.free     (free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// A header's last byte always produces a visible result next cycle.
	`TOME_ASSERT_NXT(a_last_gives_result, clk, arst_n, step && last_s1, m_tvalid)
	// A staged byte that cannot advance is kept as it is.
	`TOME_ASSERT_NXT(a_stage_holds, clk, arst_n, valid_s1 && !step,
		valid_s1 && $stable(byte_s1) && $stable(last_s1))
	// An error result never carries an MSS value or found flag.
	`TOME_ASSERT_IMP(a_err_clears_mss, clk, arst_n,
		m_tvalid && (m_tdata[18:17] != tome_pkg::StOk), m_tdata[16:0] == '0)
	// Without a found MSS the value field reads zero.
	`TOME_ASSERT_IMP(a_nofind_zero, clk, arst_n, m_tvalid && !m_tdata[16],
		m_tdata[15:0] == '0)
	// Only the three defined status codes are ever reported.
	`TOME_ASSERT_IMP(a_status_legal, clk, arst_n, m_tvalid,
		(m_tdata[18:17] == tome_pkg::StOk) || (m_tdata[18:17] == tome_pkg::StSilly) ||
		(m_tdata[18:17] == tome_pkg::StPartial))

endmodule

`default_nettype wire

// ===== rtl/tome_parser.sv =====
// ----------------------------------------------------------------------------
// TCP option MSS extractor parser
// Walks the option kind/length/body sequence one byte per step and forms the
// per-header result on the flagged last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module tome_parser (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          step,
	input  wire logic [tome_pkg::ByteW-1:0]    opt_byte,
	input  wire logic                          last_byte,
	output tome_pkg::result_t                  result
);

	tome_pkg::phase_t              phase_q;
	logic                          kind_mss_q;
	logic [tome_pkg::LeftW-1:0]    left_q;
	logic [1:0]                    index_q;
	logic [tome_pkg::MssW-1:0]     hold_q;
	logic                          seen_q;
	logic [tome_pkg::StatW-1:0]    err_q;
	logic                          stopped_q;

	tome_pkg::phase_t              phase_d;
	logic                          kind_mss_d;
	logic [tome_pkg::LeftW-1:0]    left_d;
	logic [1:0]                    index_d;
	logic [tome_pkg::MssW-1:0]     hold_d;
	logic                          seen_d;
	logic [tome_pkg::StatW-1:0]    err_d;
	logic                          stopped_d;
	logic [tome_pkg::StatW-1:0]    status;

	// Effect of one option byte on the walk state.
	always_comb begin
		phase_d    = phase_q;
		kind_mss_d = kind_mss_q;
		left_d     = left_q;
		index_d    = index_q;
		hold_d     = hold_q;
		seen_d     = seen_q;
		err_d      = err_q;
		stopped_d  = stopped_q;
		if (!stopped_q) begin
			unique case (phase_q)
				tome_pkg::PH_KIND: begin
					if (opt_byte == tome_pkg::KindEol) begin
						stopped_d = 1'b1;
					end else if (opt_byte != tome_pkg::KindNop) begin
						kind_mss_d = (opt_byte == tome_pkg::KindMss);
						phase_d    = tome_pkg::PH_LEN;
					end
				end
				tome_pkg::PH_LEN: begin
					if (opt_byte < tome_pkg::MinLen) begin
						err_d     = tome_pkg::StSilly;
						stopped_d = 1'b1;
					end else if (opt_byte > tome_pkg::AreaMax) begin
						err_d     = tome_pkg::StPartial;
						stopped_d = 1'b1;
					end else begin
						// Only an MSS option of exactly four bytes is captured.
						kind_mss_d = kind_mss_q && (opt_byte == tome_pkg::MssLen);
						left_d     = opt_byte[tome_pkg::LeftW-1:0]
							- tome_pkg::MinLen[tome_pkg::LeftW-1:0];
						index_d    = 2'd0;
						phase_d    = (left_d == '0) ? tome_pkg::PH_KIND : tome_pkg::PH_BODY;
					end
				end
				tome_pkg::PH_BODY: begin
					if (kind_mss_q) begin
						if (index_q == 2'd0) begin
							hold_d[15:8] = opt_byte;
						end else if (index_q == 2'd1) begin
							hold_d[7:0] = opt_byte;
							seen_d      = 1'b1;
						end
					end
					// The body index only needs to tell the first two bytes apart.
					index_d = (index_q == 2'd2) ? 2'd2 : index_q + 2'd1;
					left_d  = left_q - {{(tome_pkg::LeftW-1){1'b0}}, 1'b1};
					if (left_d == '0) begin
						phase_d = tome_pkg::PH_KIND;
					end
				end
				default: begin
					phase_d = tome_pkg::PH_KIND;
				end
			endcase
		end
	end

	// An option still open at the end of the area is reported as partial.
	always_comb begin
		status = err_d;
		if (!stopped_d && phase_d != tome_pkg::PH_KIND) begin
			status = tome_pkg::StPartial;
		end
		result.parse_status = status;
		result.mss_found    = (status == tome_pkg::StOk) && seen_d;
		result.mss_value    = result.mss_found ? hold_d : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= tome_pkg::PH_KIND;
			kind_mss_q <= 1'b0;
			left_q     <= '0;
			index_q    <= 2'd0;
			hold_q     <= '0;
			seen_q     <= 1'b0;
			err_q      <= tome_pkg::StOk;
			stopped_q  <= 1'b0;
		end else if (step) begin
			if (last_byte) begin
				phase_q    <= tome_pkg::PH_KIND;
				kind_mss_q <= 1'b0;
				left_q     <= '0;
				index_q    <= 2'd0;
				hold_q     <= '0;
				seen_q     <= 1'b0;
				err_q      <= tome_pkg::StOk;
				stopped_q  <= 1'b0;
			end else begin
				phase_q    <= phase_d;
				kind_mss_q <= kind_mss_d;
				left_q     <= left_d;
				index_q    <= index_d;
				hold_q     <= hold_d;
				seen_q     <= seen_d;
				err_q      <= err_d;
				stopped_q  <= stopped_d;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/tome_out_reg.sv =====
// ----------------------------------------------------------------------------
// TCP option MSS extractor output register
// Holds one finished result until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module tome_out_reg (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          load,
	input  wire tome_pkg::result_t             result,
	output logic                               free,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [tome_pkg::OutBusW-1:0]       m_tdata
);

	logic              valid_q;
	tome_pkg::result_t data_q;

	// The slot can take a new result when empty or when it empties this cycle.
	assign free     = !valid_q || m_tready;
	assign m_tvalid = valid_q;
	assign m_tdata  = {{(tome_pkg::OutBusW - tome_pkg::OutW){1'b0}},
		data_q.parse_status, data_q.mss_found, data_q.mss_value};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= result;
		end
	end

endmodule

`default_nettype wire
